[hdl/plin_pkg.sv]
// Shared constants, types and control structs of the piecewise linear interpolator.
package plin_pkg;

  localparam int MAX_KNOTS = 16;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = 5;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DIV_STEPS = DATA_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOR = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         count_t;

  localparam count_t KNOT_COUNT_RST = count_t'(2);
  localparam count_t KNOT_COUNT_MAX = count_t'(MAX_KNOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } plin_state_t;

  typedef struct packed {
    logic wr_knot;
    logic start;
    logic scan;
    logic prep;
    logic mul;
    logic div_step;
    logic load_res;
  } plin_cmd_t;

  typedef struct packed {
    logic exact_fnd;
    logic seg_fnd;
    logic scan_end;
    logic div_last;
    logic out_free;
  } plin_stat_t;

endpackage

[hdl/plin_cfg_if.sv]
// Configuration write channel carrying the knot count.
interface plin_cfg_if;
  import plin_pkg::*;
  logic   valid;
  logic   ready;
  count_t knot_count;
  modport source (output valid, output knot_count, input ready);
  modport sink (input valid, input knot_count, output ready);
endinterface

[hdl/plin_item_if.sv]
// Input item channel: knot loads and queries.
interface plin_item_if;
  import plin_pkg::*;
  logic  valid;
  logic  ready;
  logic  kind;
  idx_t  knot_index;
  data_t value_x;
  data_t value_y;
  logic  last_query;
  modport source (output valid, output kind, output knot_index, output value_x,
                  output value_y, output last_query, input ready);
  modport sink (input valid, input kind, input knot_index, input value_x,
                input value_y, input last_query, output ready);
endinterface

[hdl/plin_result_if.sv]
// Result item channel: interpolated value, status and batch end mark.
interface plin_result_if;
  import plin_pkg::*;
  logic  valid;
  logic  ready;
  data_t result_y;
  logic  status;
  logic  last;
  modport source (output valid, output result_y, output status, output last, input ready);
  modport sink (input valid, input result_y, input status, input last, output ready);
endinterface

[hdl/plin_ctrl.sv]
// Controller state machine sequencing load, scan, multiply, divide and result steps.
module plin_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  input  plin_pkg::plin_stat_t stat,
  output plin_pkg::plin_cmd_t  cmd
);
  import plin_pkg::*;

  plin_state_t state;
  plin_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_kind == KIND_QUERY) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.exact_fnd) begin
          state_next = S_FIN;
        end else if (stat.scan_end) begin
          state_next = stat.seg_fnd ? S_PREP : S_FIN;
        end
      end
      S_PREP: state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (stat.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.wr_knot = in_valid && in_kind == KIND_LOAD;
        cmd.start   = in_valid && in_kind == KIND_QUERY;
      end
      S_SCAN:  cmd.scan     = 1'b1;
      S_PREP:  cmd.prep     = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FIN:   cmd.load_res = stat.out_free;
      default: cmd          = '0;
    endcase
  end

endmodule

[hdl/plin_datapath.sv]
// Datapath: knot memories, segment scan, multiplier, restoring divider and result register.
module plin_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  plin_pkg::plin_cmd_t  cmd,
  output plin_pkg::plin_stat_t stat,
  input  logic                 cfg_wr,
  input  plin_pkg::count_t     cfg_count,
  input  plin_pkg::idx_t       in_knot_index,
  input  plin_pkg::data_t      in_x,
  input  plin_pkg::data_t      in_y,
  input  logic                 in_last,
  output logic                 res_valid,
  input  logic                 res_ready,
  output plin_pkg::data_t      res_y,
  output logic                 res_status,
  output logic                 res_last
);
  import plin_pkg::*;

  data_t mem_x [MAX_KNOTS];
  data_t mem_y [MAX_KNOTS];

  count_t knot_count;
  count_t eff_count;
  count_t idx;
  logic   rd_en;
  logic   rd_vld;
  data_t  rd_x;
  data_t  rd_y;
  data_t  qx;
  logic   qlast;
  logic   prev_vld;
  data_t  prev_x;
  data_t  prev_y;
  logic   exact_fnd;
  data_t  exact_y;
  logic   seg_fnd;
  data_t  sj_x;
  data_t  sj_y;
  data_t  sk_x;
  data_t  sk_y;

  logic              neg;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] span_t;
  logic [DATA_W-1:0] span_dx;
  logic [DATA_W:0]   dy_w;
  logic [DATA_W:0]   dy_neg;
  logic [DATA_W:0]   t_w;
  logic [DATA_W:0]   dx_w;
  logic [PROD_W-1:0] prod_w;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DCNT_W-1:0] dcnt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;
  data_t             seg_y;

  assign eff_count = (knot_count > KNOT_COUNT_MAX) ? KNOT_COUNT_MAX : knot_count;
  assign rd_en     = idx < eff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= KNOT_COUNT_RST;
    end else if (cfg_wr) begin
      knot_count <= cfg_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_knot) begin
      mem_x[in_knot_index] <= in_x;
      mem_y[in_knot_index] <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_en) begin
      rd_x <= mem_x[idx[IDX_W-1:0]];
      rd_y <= mem_y[idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rd_vld    <= 1'b0;
      prev_vld  <= 1'b0;
      exact_fnd <= 1'b0;
      seg_fnd   <= 1'b0;
    end else if (cmd.start) begin
      qx        <= in_x;
      qlast     <= in_last;
      idx       <= '0;
      rd_vld    <= 1'b0;
      prev_vld  <= 1'b0;
      exact_fnd <= 1'b0;
      seg_fnd   <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld <= rd_en;
      if (rd_en) idx <= idx + count_t'(1);
      if (rd_vld) begin
        if (!exact_fnd && rd_x == qx) begin
          exact_fnd <= 1'b1;
          exact_y   <= rd_y;
        end
        if (prev_vld && !seg_fnd && prev_x < qx && qx < rd_x) begin
          seg_fnd <= 1'b1;
          sj_x    <= prev_x;
          sj_y    <= prev_y;
          sk_x    <= rd_x;
          sk_y    <= rd_y;
        end
        prev_x   <= rd_x;
        prev_y   <= rd_y;
        prev_vld <= 1'b1;
      end
    end
  end

  assign dy_w   = {sk_y[DATA_W-1], sk_y} - {sj_y[DATA_W-1], sj_y};
  assign dy_neg = '0 - dy_w;
  assign t_w    = {qx[DATA_W-1], qx} - {sj_x[DATA_W-1], sj_x};
  assign dx_w   = {sk_x[DATA_W-1], sk_x} - {sj_x[DATA_W-1], sj_x};
  assign prod_w = PROD_W'(mag) * PROD_W'(span_t);
  assign trial  = {rem, quo[DATA_W-1]};
  assign diff   = trial - {1'b0, span_dx};
  assign ge     = trial >= {1'b0, span_dx};
  assign seg_y  = neg ? (sj_y - data_t'(quo)) : (sj_y + data_t'(quo));

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg     <= dy_w[DATA_W];
      mag     <= dy_w[DATA_W] ? dy_neg[DATA_W-1:0] : dy_w[DATA_W-1:0];
      span_t  <= t_w[DATA_W-1:0];
      span_dx <= dx_w[DATA_W-1:0];
    end
    if (cmd.mul) begin
      rem  <= prod_w[PROD_W-1:DATA_W];
      quo  <= prod_w[DATA_W-1:0];
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo  <= {quo[DATA_W-2:0], ge};
      dcnt <= dcnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      res_last <= qlast;
      if (exact_fnd) begin
        res_y      <= exact_y;
        res_status <= STATUS_OK;
      end else if (seg_fnd) begin
        res_y      <= seg_y;
        res_status <= STATUS_OK;
      end else begin
        res_y      <= '0;
        res_status <= STATUS_OOR;
      end
    end
  end

  assign stat.exact_fnd = exact_fnd;
  assign stat.seg_fnd   = seg_fnd;
  assign stat.scan_end  = !rd_vld && !rd_en;
  assign stat.div_last  = dcnt == DCNT_W'(DIV_STEPS - 1);
  assign stat.out_free  = !res_valid || res_ready;

endmodule

[hdl/piecewise_linear_interpolator_core.sv]
// Piecewise linear interpolator top level: controller, datapath and channel wiring.
//
// Channels: cfg writes the knot count (always ready, reset value 2, values
// above 16 act as 16). item carries loads (kind 0) and queries (kind 1).
// result carries one item per query: result_y, status (1 = out of range,
// result_y zero) and last, a copy of last_query.
// A load writes knot slot knot_index; it gives no result. A query scans
// the knot memory one slot per cycle (registered read) and ends early
// when an exact knot match is found. A segment hit then forms the
// differences, passes through the 32x32 multiplier and the restoring
// divider, one quotient bit per cycle, and then loads the result
// register; an exact match or a miss skips the division and goes
// straight to loading the result. Once the result register is loaded,
// the next item can be taken in the cycle after.
// One query is in flight at a time; item.ready is high only while idle.
// The result register holds its item while result.ready is low; the block
// takes loads meanwhile and stalls a finished query until the register
// frees. Reset is synchronous; it empties the result register and
// restores the knot count, and the knot memory keeps undefined contents.
module piecewise_linear_interpolator_core (
  input  logic          clk,
  input  logic          rst,
  plin_cfg_if.sink      cfg,
  plin_item_if.sink     item,
  plin_result_if.source result
);
  import plin_pkg::*;

  plin_cmd_t  cmd;
  plin_stat_t stat;

  assign cfg.ready = 1'b1;

  plin_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plin_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr        (cfg.valid),
    .cfg_count     (cfg.knot_count),
    .in_knot_index (item.knot_index),
    .in_x          (item.value_x),
    .in_y          (item.value_y),
    .in_last       (item.last_query),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_y         (result.result_y),
    .res_status    (result.status),
    .res_last      (result.last)
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == STATUS_OOR |-> result.result_y == '0)
    else $error("out of range result carries nonzero value");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |-> stat.out_free)
    else $error("result loaded into occupied register");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.kind == KIND_QUERY |=> !item.ready)
    else $error("new item taken while query in flight");

endmodule
